[design/clt_pkg.sv]
// Shared types and constants for the command-line tokenizer.
// Used by clt_step, clt_outbuf and command_line_tokenizer; no dependencies.
package clt_pkg;

  localparam int MAX_RUN = 255;
  localparam int RUN_CAP = (MAX_RUN < 255) ? MAX_RUN : 255;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [7:0] RUN_CAP_VAL = RUN_CAP[7:0];

  typedef struct packed {
    logic       in_quote;
    logic [7:0] backslash_run;
    logic       escape_pending;
    logic       arg_nonempty;
    logic       overflow_seen;
  } clt_state_t;

  typedef struct packed {
    logic [7:0] backslashes_before;
    logic       has_char;
    logic [7:0] out_char;
    logic       arg_end;
    logic       arg_discard;
    logic       run_overflow;
  } clt_result_t;

endpackage

[design/clt_step.sv]
// Per-byte tokenizer step: next line state and the result for one input byte.
// Depends on clt_pkg for the state and result types and the character codes.
module clt_step (
  input  logic                 win32_mode,
  input  clt_pkg::clt_state_t  state,
  input  logic [7:0]           in_char,
  input  logic                 last,
  output clt_pkg::clt_state_t  state_next,
  output clt_pkg::clt_result_t result,
  output logic                 result_valid
);
  import clt_pkg::*;

  logic       is_bslash;
  logic       is_quote;
  logic       is_blank;
  logic       below_cap;
  logic       classify;
  logic       take_run;
  logic [7:0] bs;
  logic       hc;
  logic [7:0] oc;
  logic       end_arg;
  logic       disc;
  logic       ovf;
  logic       ovf_seen;
  logic [7:0] run;
  logic       esc;
  logic       quote;
  logic       nonempty;

  assign is_bslash = (in_char == CH_BSLASH);
  assign is_quote  = (in_char == CH_QUOTE);
  assign is_blank  = (in_char == CH_SPACE) || (in_char == CH_TAB) ||
                     (in_char == CH_CR) || (in_char == CH_LF);
  assign below_cap = (state.backslash_run < RUN_CAP_VAL);

  always_comb begin
    bs       = 8'd0;
    hc       = 1'b0;
    oc       = 8'd0;
    end_arg  = 1'b0;
    disc     = 1'b0;
    ovf      = 1'b0;
    classify = 1'b0;
    take_run = 1'b0;
    run      = state.backslash_run;
    esc      = state.escape_pending;
    ovf_seen = state.overflow_seen;
    quote    = state.in_quote;
    nonempty = state.arg_nonempty;

    if (win32_mode) begin
      esc = 1'b0;
      if (is_bslash) begin
        if (below_cap) begin
          run = state.backslash_run + 8'd1;
        end else begin
          ovf_seen = 1'b1;
        end
        if (last) begin
          bs       = run;
          take_run = 1'b1;
        end
      end else if (is_quote) begin
        bs       = {1'b0, state.backslash_run[7:1]};
        take_run = 1'b1;
        if (state.backslash_run[0]) begin
          hc = 1'b1;
          oc = CH_QUOTE;
        end else begin
          classify = 1'b1;
        end
      end else begin
        bs       = state.backslash_run;
        take_run = 1'b1;
        classify = 1'b1;
      end
    end else begin
      bs       = state.backslash_run;
      take_run = 1'b1;
      if (state.escape_pending) begin
        esc = 1'b0;
        hc  = 1'b1;
        oc  = in_char;
      end else if (is_bslash) begin
        esc = 1'b1;
      end else begin
        classify = 1'b1;
      end
    end

    if (take_run) begin
      ovf      = ovf_seen;
      ovf_seen = 1'b0;
      run      = 8'd0;
    end
    if (bs != 8'd0) begin
      nonempty = 1'b1;
    end

    if (classify) begin
      priority if (quote) begin
        if (is_quote) begin
          quote = 1'b0;
        end else begin
          hc = 1'b1;
          oc = in_char;
        end
      end else if (is_blank) begin
        end_arg  = nonempty;
        nonempty = 1'b0;
      end else if (is_quote) begin
        quote = 1'b1;
      end else begin
        hc = 1'b1;
        oc = in_char;
      end
    end
    if (hc) begin
      nonempty = 1'b1;
    end

    // The end of a line closes or drops the open argument and clears the state.
    if (last) begin
      if (quote) begin
        disc = 1'b1;
      end else if (nonempty) begin
        end_arg = 1'b1;
      end
      quote    = 1'b0;
      run      = 8'd0;
      esc      = 1'b0;
      nonempty = 1'b0;
      ovf_seen = 1'b0;
    end
  end

  assign state_next.in_quote       = quote;
  assign state_next.backslash_run  = run;
  assign state_next.escape_pending = esc;
  assign state_next.arg_nonempty   = nonempty;
  assign state_next.overflow_seen  = ovf_seen;

  assign result.backslashes_before = bs;
  assign result.has_char           = hc;
  assign result.out_char           = oc;
  assign result.arg_end            = end_arg;
  assign result.arg_discard        = disc;
  assign result.run_overflow       = ovf;

  assign result_valid = (bs != 8'd0) || hc || end_arg || disc || ovf;

endmodule

[design/clt_outbuf.sv]
// Two-entry result buffer: an output register plus a skid entry.
// Depends on clt_pkg for the result type.
module clt_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  clt_pkg::clt_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output clt_pkg::clt_result_t out_data
);
  import clt_pkg::*;

  logic        main_valid;
  logic        skid_valid;
  clt_result_t main_data;
  clt_result_t skid_data;
  logic        pop;

  assign pop       = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  // The upstream side may push only while the skid entry is free.
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= push_data;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= push_data;
      end else begin
        main_data <= push_data;
      end
    end
  end

endmodule

[design/command_line_tokenizer.sv]
// Command-line tokenizer top level: one byte per transaction, at most one result.
// Each result is registered in the output buffer before it appears on the output.
// Throughput: one byte per cycle while in_stall is low; the line state updates in a single pass per byte.
// A two-entry result buffer keeps input flowing while one result waits downstream.
// Reset (rst, synchronous) clears the line state and buffer and sets Win32 mode.
// Depends on clt_pkg, clt_step and clt_outbuf.
module command_line_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] backslashes_before,
  output logic       has_char,
  output logic [7:0] out_char,
  output logic       arg_end,
  output logic       arg_discard,
  output logic       run_overflow
);
  import clt_pkg::*;

  logic        win32_mode;
  clt_state_t  state;
  clt_state_t  state_next;
  clt_result_t step_result;
  logic        step_result_valid;
  logic        accept;
  logic        buf_full;
  clt_result_t out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  clt_step u_step (
    .win32_mode   (win32_mode),
    .state        (state),
    .in_char      (in_char),
    .last         (last),
    .state_next   (state_next),
    .result       (step_result),
    .result_valid (step_result_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win32_mode <= 1'b1;
    end else if (cfg_we) begin
      win32_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  clt_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && step_result_valid),
    .push_data (step_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign backslashes_before = out_data.backslashes_before;
  assign has_char           = out_data.has_char;
  assign out_char           = out_data.out_char;
  assign arg_end            = out_data.arg_end;
  assign arg_discard        = out_data.arg_discard;
  assign run_overflow       = out_data.run_overflow;

endmodule
